@@ design/mp3_joint_stereo_pair_defines.svh @@
// assertion macros shared by the joint stereo pair design
`ifndef MP3_JOINT_STEREO_PAIR_DEFINES_SVH
`define MP3_JOINT_STEREO_PAIR_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define MP3JS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("joint stereo pair check failed");

// antecedent implies consequent in the next cycle
`define MP3JS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("joint stereo pair check failed");

`endif

@@ design/mp3js_pkg.sv @@
// types, register indexes and coefficient tables of the joint stereo pair
package mp3js_pkg;

  // configuration register indexes
  localparam logic [2:0] RegJointStereo     = 3'd0;
  localparam logic [2:0] RegMsEnable        = 3'd1;
  localparam logic [2:0] RegIntensityEnable = 3'd2;
  localparam logic [2:0] RegIsMpeg1         = 3'd3;
  localparam logic [2:0] RegDownmixEnable   = 3'd4;
  localparam logic [2:0] RegLsfScaleSel     = 3'd5;

  // border used when intensity stereo is off
  localparam logic [4:0] BandLimit = 5'd22;

  // q0.15 sqrt(1/2)
  localparam logic [14:0] SqrtHalf = 15'h5a82;

  // mpeg-1 tangent tables
  localparam logic [14:0] TAN_LEFT [7] = '{
    15'h0000, 15'h1b0c, 15'h2ed9, 15'h4000, 15'h5126, 15'h64f3, 15'h7fff
  };
  localparam logic [14:0] TAN_RIGHT [7] = '{
    15'h7fff, 15'h64f3, 15'h5126, 15'h4000, 15'h2ed9, 15'h1b0c, 15'h0000
  };

  // mpeg-2 tables, one per intensity scale
  localparam logic [14:0] LSF_TAB0 [16] = '{
    15'h7fff, 15'h6ba2, 15'h5a82, 15'h4c1b, 15'h4000, 15'h35d1, 15'h2d41, 15'h260d,
    15'h2000, 15'h1ae8, 15'h16a0, 15'h1306, 15'h1000, 15'h0d74, 15'h0b50, 15'h0983
  };
  localparam logic [14:0] LSF_TAB1 [16] = '{
    15'h7fff, 15'h5a82, 15'h4000, 15'h2d41, 15'h2000, 15'h16a0, 15'h1000, 15'h0b50,
    15'h0800, 15'h05a8, 15'h0400, 15'h02d4, 15'h0200, 15'h016a, 15'h0100, 15'h00b5
  };

  typedef struct packed {
    logic joint_stereo;
    logic ms_enable;
    logic intensity_enable;
    logic is_mpeg1;
    logic downmix_enable;
    logic lsf_scale_sel;
  } cfg_t;

  // decoded operation for one pair: left = mul + addend, right = mul or bypass
  typedef struct packed {
    logic        l_mul_en;
    logic [31:0] l_mul_a;
    logic [14:0] l_coef;
    logic [31:0] l_add;
    logic        r_mul_en;
    logic [31:0] r_mul_a;
    logic [14:0] r_coef;
    logic [31:0] r_byp;
  } op_t;

endpackage

@@ design/mp3js_decode.sv @@
// path selection and operand setup for one coefficient pair
module mp3js_decode import mp3js_pkg::*; (
  input  cfg_t        cfg,
  input  logic [31:0] left_sample,
  input  logic [31:0] right_sample,
  input  logic [4:0]  band_number,
  input  logic [4:0]  intensity_border,
  input  logic [4:0]  intensity_position,
  input  logic [4:0]  illegal_position,
  output op_t         op
);

  logic [31:0] sum;
  logic [31:0] diff;
  logic [31:0] half_sum;
  logic [31:0] half_l;
  logic [4:0]  border;
  logic        bad_pos;
  logic        plain;
  logic [2:0]  idx1;
  logic [3:0]  idx_dm;
  logic [5:0]  pos_up;
  logic [3:0]  idx_odd;
  logic [3:0]  idx_even;
  logic [14:0] lsf_dm;
  logic [14:0] lsf_odd;
  logic [14:0] lsf_even;

  // shared sums and halves, all wrapping at 32 bits
  assign sum      = left_sample + right_sample;
  assign diff     = left_sample - right_sample;
  assign half_sum = {sum[31], sum[31:1]};
  assign half_l   = {left_sample[31], left_sample[31:1]};

  // band classification
  assign border  = cfg.intensity_enable ? intensity_border : BandLimit;
  assign bad_pos = cfg.intensity_enable && (intensity_position == illegal_position);
  assign plain   = (band_number < border) || bad_pos;

  // clamped table indexes
  assign idx1    = (intensity_position > 5'd6) ? 3'd6 : intensity_position[2:0];
  assign idx_dm  = (intensity_position > 5'd15) ? 4'd15 : intensity_position[3:0];
  assign pos_up  = {1'b0, intensity_position} + 6'd1;
  assign idx_odd = (pos_up[5:1] > 5'd15) ? 4'd15 : pos_up[4:1];
  assign idx_even = intensity_position[4:1];

  assign lsf_dm   = cfg.lsf_scale_sel ? LSF_TAB1[idx_dm]   : LSF_TAB0[idx_dm];
  assign lsf_odd  = cfg.lsf_scale_sel ? LSF_TAB1[idx_odd]  : LSF_TAB0[idx_odd];
  assign lsf_even = cfg.lsf_scale_sel ? LSF_TAB1[idx_even] : LSF_TAB0[idx_even];

  // operand selection per path
  always_comb begin
    op.l_mul_en = 1'b0;
    op.l_mul_a  = left_sample;
    op.l_coef   = '0;
    op.l_add    = left_sample;
    op.r_mul_en = 1'b0;
    op.r_mul_a  = left_sample;
    op.r_coef   = '0;
    op.r_byp    = right_sample;
    if (!cfg.joint_stereo) begin
      if (cfg.downmix_enable) begin
        op.l_add = half_sum;
      end
    end else if (plain) begin
      if (cfg.ms_enable) begin
        op.l_mul_en = 1'b1;
        op.l_coef   = SqrtHalf;
        op.l_add    = '0;
        if (!cfg.downmix_enable) begin
          op.l_mul_a  = sum;
          op.r_mul_en = 1'b1;
          op.r_mul_a  = diff;
          op.r_coef   = SqrtHalf;
        end
      end else if (cfg.downmix_enable) begin
        op.l_add = half_sum;
      end
    end else if (cfg.intensity_enable) begin
      if (cfg.is_mpeg1) begin
        if (cfg.downmix_enable) begin
          op.l_add = half_l;
        end else begin
          op.l_mul_en = 1'b1;
          op.l_coef   = TAN_LEFT[idx1];
          op.l_add    = '0;
          op.r_mul_en = 1'b1;
          op.r_coef   = TAN_RIGHT[idx1];
        end
      end else if (cfg.downmix_enable) begin
        op.l_mul_en = 1'b1;
        op.l_mul_a  = half_l;
        op.l_coef   = lsf_dm;
        op.l_add    = half_l;
      end else if (intensity_position[0]) begin
        op.l_mul_en = 1'b1;
        op.l_coef   = lsf_odd;
        op.l_add    = '0;
        op.r_byp    = left_sample;
      end else begin
        op.r_mul_en = 1'b1;
        op.r_coef   = lsf_even;
      end
    end
  end

endmodule

@@ design/mp3_joint_stereo_pair.sv @@
// top level of the layer iii joint stereo pair processor
//
// Usage:
// - input channel (in_valid/in_ready) carries one left/right coefficient
//   word with its band number, intensity border, intensity position and
//   illegal position; one processed word leaves on out_valid/out_ready
// - configuration channel (cfg_valid/cfg_ready) writes one mode bit per
//   word, bit 0 of cfg_data into the register selected by cfg_index;
//   unknown indexes are ignored, cfg_ready is always high; write only
//   while no word is in flight
// - out_valid rises once the accepted word has passed the register stages
//   in order (decode, multiply, align and add)
// - throughput: one word per cycle while out_ready stays high, set by the
//   three register stages with one 32x16 multiplier per channel side
// - reset (rst_n low, synchronous) empties the pipeline and loads the mode
//   defaults: everything off, mpeg-1 tables selected
// - when out_ready is low the result holds in the output register; earlier
//   stages keep filling empty slots and in_ready drops only once every
//   stage holds a word
`include "mp3_joint_stereo_pair_defines.svh"

module mp3_joint_stereo_pair import mp3js_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic        cfg_data,
  // input words
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_left_sample,
  input  logic [31:0] in_right_sample,
  input  logic [4:0]  in_band_number,
  input  logic [4:0]  in_intensity_border,
  input  logic [4:0]  in_intensity_position,
  input  logic [4:0]  in_illegal_position,
  // result words
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_left_out,
  output logic [31:0] out_right_out
);

  cfg_t cfg_r;
  op_t  dec_op;
  op_t  s1_op_r;
  logic s1_valid_r;
  logic s2_valid_r;
  logic s3_valid_r;
  logic s1_adv;
  logic s2_adv;
  logic s3_adv;

  logic signed [47:0] l_prod_r;
  logic signed [47:0] r_prod_r;
  logic               l_mul_en_r;
  logic               r_mul_en_r;
  logic [31:0]        l_add_r;
  logic [31:0]        r_byp_r;

  logic [31:0] left_nxt;
  logic [31:0] right_nxt;
  logic [31:0] left_r;
  logic [31:0] right_r;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{joint_stereo: 1'b0, ms_enable: 1'b0, intensity_enable: 1'b0,
                 is_mpeg1: 1'b1, downmix_enable: 1'b0, lsf_scale_sel: 1'b0};
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        RegJointStereo:     cfg_r.joint_stereo     <= cfg_data;
        RegMsEnable:        cfg_r.ms_enable        <= cfg_data;
        RegIntensityEnable: cfg_r.intensity_enable <= cfg_data;
        RegIsMpeg1:         cfg_r.is_mpeg1         <= cfg_data;
        RegDownmixEnable:   cfg_r.downmix_enable   <= cfg_data;
        RegLsfScaleSel:     cfg_r.lsf_scale_sel    <= cfg_data;
        default: ;
      endcase
    end
  end

  // per-stage flow control: a stage loads when it is empty or draining
  assign s3_adv   = !s3_valid_r || out_ready;
  assign s2_adv   = !s2_valid_r || s3_adv;
  assign s1_adv   = !s1_valid_r || s2_adv;
  assign in_ready = s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (s1_adv) s1_valid_r <= in_valid;
      if (s2_adv) s2_valid_r <= s1_valid_r;
      if (s3_adv) s3_valid_r <= s2_valid_r;
    end
  end

  // stage 1: path decode and operand select
  mp3js_decode u_decode (
    .cfg                (cfg_r),
    .left_sample        (in_left_sample),
    .right_sample       (in_right_sample),
    .band_number        (in_band_number),
    .intensity_border   (in_intensity_border),
    .intensity_position (in_intensity_position),
    .illegal_position   (in_illegal_position),
    .op                 (dec_op)
  );

  always_ff @(posedge clk) begin
    if (s1_adv && in_valid) s1_op_r <= dec_op;
  end

  // stage 2: signed by unsigned q0.15 products
  always_ff @(posedge clk) begin
    if (s2_adv && s1_valid_r) begin
      l_prod_r   <= 48'($signed(s1_op_r.l_mul_a) * $signed({1'b0, s1_op_r.l_coef}));
      r_prod_r   <= 48'($signed(s1_op_r.r_mul_a) * $signed({1'b0, s1_op_r.r_coef}));
      l_mul_en_r <= s1_op_r.l_mul_en;
      r_mul_en_r <= s1_op_r.r_mul_en;
      l_add_r    <= s1_op_r.l_add;
      r_byp_r    <= s1_op_r.r_byp;
    end
  end

  // stage 3: shift by 15, keep low 32 bits, add left addend
  assign left_nxt  = (l_mul_en_r ? l_prod_r[46:15] : 32'd0) + l_add_r;
  assign right_nxt = r_mul_en_r ? r_prod_r[46:15] : r_byp_r;

  always_ff @(posedge clk) begin
    if (s3_adv && s2_valid_r) begin
      left_r  <= left_nxt;
      right_r <= right_nxt;
    end
  end

  assign out_valid     = s3_valid_r;
  assign out_left_out  = left_r;
  assign out_right_out = right_r;

  // pipeline checks
  `MP3JS_ASSERT_NEXT(a_in_to_s1, in_valid && in_ready, s1_valid_r)
  `MP3JS_ASSERT_NEXT(a_s1_to_s2, s1_valid_r && s2_adv, s2_valid_r)
  `MP3JS_ASSERT_NEXT(a_s2_to_out, s2_valid_r && s3_adv, out_valid)
  `MP3JS_ASSERT_SAME(a_empty_ready, !s1_valid_r && !s2_valid_r && !s3_valid_r, in_ready)

endmodule

@@ verif/mp3_joint_stereo_pair_checker.sv @@
// checker of the joint stereo pair: predicts each result word and compares it
module mp3_joint_stereo_pair_checker import mp3js_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic        cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] in_left_sample,
  input  logic [31:0] in_right_sample,
  input  logic [4:0]  in_band_number,
  input  logic [4:0]  in_intensity_border,
  input  logic [4:0]  in_intensity_position,
  input  logic [4:0]  in_illegal_position,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_left_out,
  input  logic [31:0] out_right_out,
  output int          fail_count,
  output int          words_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] left;
    logic [31:0] right;
  } pair_t;

  // band border that applies while intensity stereo is off
  localparam logic [4:0] NO_INTENSITY_BORDER = 5'd22;
  localparam logic [14:0] HALF_ROOT = 15'h5a82;
  localparam int TAN_LAST = 6;
  localparam int LSF_LAST = 15;

  // mpeg-1 tangent coefficients, indexed by position
  localparam logic [14:0] TAN_L_COEF [7] = '{
    15'h0000, 15'h1b0c, 15'h2ed9, 15'h4000, 15'h5126, 15'h64f3, 15'h7fff
  };
  localparam logic [14:0] TAN_R_COEF [7] = '{
    15'h7fff, 15'h64f3, 15'h5126, 15'h4000, 15'h2ed9, 15'h1b0c, 15'h0000
  };
  // mpeg-2 coefficients, first index is the intensity scale
  localparam logic [14:0] LSF_COEF [2][16] = '{
    '{15'h7fff, 15'h6ba2, 15'h5a82, 15'h4c1b, 15'h4000, 15'h35d1, 15'h2d41, 15'h260d,
      15'h2000, 15'h1ae8, 15'h16a0, 15'h1306, 15'h1000, 15'h0d74, 15'h0b50, 15'h0983},
    '{15'h7fff, 15'h5a82, 15'h4000, 15'h2d41, 15'h2000, 15'h16a0, 15'h1000, 15'h0b50,
      15'h0800, 15'h05a8, 15'h0400, 15'h02d4, 15'h0200, 15'h016a, 15'h0100, 15'h00b5}
  };

  localparam cfg_t MODES_AT_RESET = '{
    joint_stereo: 1'b0, ms_enable: 1'b0, intensity_enable: 1'b0,
    is_mpeg1: 1'b1, downmix_enable: 1'b0, lsf_scale_sel: 1'b0
  };

  cfg_t  modes;
  pair_t expected_pairs[$];
  int    mismatches = 0;

  assign fail_count = mismatches;

  // signed sample times q0.15 coefficient, shifted down, low 32 bits kept
  function automatic logic [31:0] frac_mul(logic [31:0] a, logic [14:0] c);
    logic signed [63:0] prod;
    prod = $signed({{32{a[31]}}, a}) * $signed({49'd0, c});
    return prod[46:15];
  endfunction

  function automatic logic [31:0] halve(logic [31:0] v);
    return {v[31], v[31:1]};
  endfunction

  // expected output word for one coefficient pair under the given modes
  function automatic pair_t process_pair(cfg_t m, logic [31:0] l, logic [31:0] r,
                                         logic [4:0] band, logic [4:0] border,
                                         logic [4:0] pos, logic [4:0] illegal);
    pair_t       res;
    logic [4:0]  limit;
    logic        plain;
    logic [31:0] h;
    int          k;
    res.left  = l;
    res.right = r;
    if (!m.joint_stereo) begin
      if (m.downmix_enable) res.left = halve(l + r);
    end else begin
      limit = m.intensity_enable ? border : NO_INTENSITY_BORDER;
      plain = (band < limit) || (m.intensity_enable && (pos == illegal));
      if (plain) begin
        // mid/side or left/right
        if (m.ms_enable) begin
          if (m.downmix_enable) begin
            res.left = frac_mul(l, HALF_ROOT);
          end else begin
            res.left  = frac_mul(l + r, HALF_ROOT);
            res.right = frac_mul(l - r, HALF_ROOT);
          end
        end else if (m.downmix_enable) begin
          res.left = halve(l + r);
        end
      end else if (m.intensity_enable) begin
        if (m.is_mpeg1) begin
          k = (pos > TAN_LAST) ? TAN_LAST : int'(pos);
          if (m.downmix_enable) begin
            res.left = halve(l);
          end else begin
            res.left  = frac_mul(l, TAN_L_COEF[k]);
            res.right = frac_mul(l, TAN_R_COEF[k]);
          end
        end else if (m.downmix_enable) begin
          // position used unhalved here
          h = halve(l);
          k = (pos > LSF_LAST) ? LSF_LAST : int'(pos);
          res.left = h + frac_mul(h, LSF_COEF[m.lsf_scale_sel][k]);
        end else if (pos[0]) begin
          // odd position scales the left side
          k = int'(pos[4:1]) + 1;
          if (k > LSF_LAST) k = LSF_LAST;
          res.right = l;
          res.left  = frac_mul(l, LSF_COEF[m.lsf_scale_sel][k]);
        end else begin
          // even position scales the right side
          k = int'(pos[4:1]);
          res.right = frac_mul(l, LSF_COEF[m.lsf_scale_sel][k]);
        end
      end
    end
    return res;
  endfunction

  // result check first, then new expectation, then mode writes
  always @(posedge clk) begin
    pair_t want;
    if (!rst_n) begin
      modes <= MODES_AT_RESET;
      expected_pairs.delete();
      words_pending <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_pairs.size() == 0) begin
          $error("result word with no expectation: left_out %h right_out %h",
                 out_left_out, out_right_out);
          mismatches = mismatches + 1;
        end else begin
          want = expected_pairs.pop_front();
          if (out_left_out !== want.left) begin
            $error("left_out: expected %h, got %h", want.left, out_left_out);
            mismatches = mismatches + 1;
          end
          if (out_right_out !== want.right) begin
            $error("right_out: expected %h, got %h", want.right, out_right_out);
            mismatches = mismatches + 1;
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_pairs.push_back(process_pair(modes, in_left_sample, in_right_sample,
                                              in_band_number, in_intensity_border,
                                              in_intensity_position,
                                              in_illegal_position));
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          RegJointStereo:     modes.joint_stereo     <= cfg_data;
          RegMsEnable:        modes.ms_enable        <= cfg_data;
          RegIntensityEnable: modes.intensity_enable <= cfg_data;
          RegIsMpeg1:         modes.is_mpeg1         <= cfg_data;
          RegDownmixEnable:   modes.downmix_enable   <= cfg_data;
          RegLsfScaleSel:     modes.lsf_scale_sel    <= cfg_data;
          default: ;
        endcase
      end
      words_pending <= expected_pairs.size();
    end
  end

endmodule

@@ verif/tb_mp3_joint_stereo_pair.sv @@
// testbench top of the joint stereo pair: clock, reset, stimulus and verdict
module tb_mp3_joint_stereo_pair import mp3js_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] FIRST_SPARE_INDEX = 3'd6;
  localparam logic [2:0] LAST_SPARE_INDEX  = 3'd7;
  localparam int RANDOM_PHASES   = 10;
  localparam int WORDS_PER_PHASE = 55;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic        cfg_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_left_sample = '0;
  logic [31:0] in_right_sample = '0;
  logic [4:0]  in_band_number = '0;
  logic [4:0]  in_intensity_border = '0;
  logic [4:0]  in_intensity_position = '0;
  logic [4:0]  in_illegal_position = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_left_out;
  logic [31:0] out_right_out;
  int          fail_count;
  int          words_pending;

  int idle_pct = 0;
  int stall_pct = 0;

  mp3_joint_stereo_pair u_dut (.*);

  mp3_joint_stereo_pair_checker u_checker (.*);

  // 4 ns clock, first rising edge at 2 ns
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // run limit
  initial begin
    #2000000;
    $display("mp3_joint_stereo_pair: mismatch");
    $finish;
  end

  function automatic cfg_t make_modes(logic js, logic ms, logic ie, logic m1,
                                      logic dm, logic sc);
    cfg_t m;
    m.joint_stereo     = js;
    m.ms_enable        = ms;
    m.intensity_enable = ie;
    m.is_mpeg1         = m1;
    m.downmix_enable   = dm;
    m.lsf_scale_sel    = sc;
    return m;
  endfunction

  function automatic logic mode_bit(cfg_t m, logic [2:0] idx);
    case (idx)
      RegJointStereo:     return m.joint_stereo;
      RegMsEnable:        return m.ms_enable;
      RegIntensityEnable: return m.intensity_enable;
      RegIsMpeg1:         return m.is_mpeg1;
      RegDownmixEnable:   return m.downmix_enable;
      RegLsfScaleSel:     return m.lsf_scale_sel;
      default:            return 1'b0;
    endcase
  endfunction

  // joint stereo and intensity lean on so the deeper paths get most words
  function automatic cfg_t random_modes();
    return make_modes($urandom_range(9) < 8, 1'($urandom_range(1)),
                      $urandom_range(9) < 7, 1'($urandom_range(1)),
                      1'($urandom_range(1)), 1'($urandom_range(1)));
  endfunction

  // extremes, small values and full-range noise
  function automatic logic [31:0] pick_sample();
    int sel;
    sel = $urandom_range(9);
    case (sel)
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      4, 5:    return 32'($urandom_range(2047)) - 32'd1024;
      default: return $urandom;
    endcase
  endfunction

  // drop valid and wait until every result word has come back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
  endtask

  // write all six mode bits, sometimes followed by a spare index
  task automatic program_modes(cfg_t m);
    settle();
    for (int i = 0; i < 6; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data  <= mode_bit(m, 3'(i));
      do @(posedge clk); while (!cfg_ready);
    end
    if ($urandom_range(1)) begin
      cfg_valid <= 1'b1;
      cfg_index <= 3'($urandom_range(LAST_SPARE_INDEX, FIRST_SPARE_INDEX));
      cfg_data  <= 1'($urandom_range(1));
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  // present one coefficient word, after random idle cycles
  task automatic send_pair(logic [31:0] l, logic [31:0] r, logic [4:0] band,
                           logic [4:0] border, logic [4:0] pos, logic [4:0] illegal);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid              <= 1'b1;
    in_left_sample        <= l;
    in_right_sample       <= r;
    in_band_number        <= band;
    in_intensity_border   <= border;
    in_intensity_position <= pos;
    in_illegal_position   <= illegal;
    do @(posedge clk); while (!in_ready);
  endtask

  // mostly legal band/border ranges and distinct positions, some noise
  task automatic send_random_pair();
    logic [4:0] band;
    logic [4:0] border;
    logic [4:0] pos;
    logic [4:0] illegal;
    band    = ($urandom_range(9) < 7) ? 5'($urandom_range(21)) : 5'($urandom_range(31));
    border  = ($urandom_range(9) < 7) ? 5'($urandom_range(22)) : 5'($urandom_range(31));
    pos     = $urandom_range(1) ? 5'($urandom_range(7)) : 5'($urandom_range(31));
    illegal = ($urandom_range(99) < 15) ? pos : 5'($urandom_range(31));
    send_pair(pick_sample(), pick_sample(), band, border, pos, illegal);
  endtask

  // stimulus
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_pct  = 25;
    stall_pct = 25;

    // modes at reset: plain pass-through
    send_pair(32'h8000_0000, 32'h7fff_ffff, 5'd0, 5'd0, 5'd0, 5'd0);

    // plain downmix, sum overflow both ways
    program_modes(make_modes(1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0));
    send_pair(32'h7fff_ffff, 32'h7fff_ffff, 5'd3, 5'd0, 5'd0, 5'd0);
    send_pair(32'h8000_0000, 32'h8000_0000, 5'd31, 5'd31, 5'd31, 5'd31);

    // mid/side below the fixed border, pass-through at and beyond it
    program_modes(make_modes(1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0));
    send_pair(32'h7fff_ffff, 32'h8000_0000, 5'd21, 5'd0, 5'd5, 5'd5);
    send_pair(32'h1234_5678, 32'hfedc_ba98, 5'd22, 5'd0, 5'd0, 5'd0);
    send_pair(32'hffff_ffff, 32'h0000_0001, 5'd31, 5'd31, 5'd31, 5'd0);

    // mpeg-1 intensity: table ends, clamp, illegal position, border extremes
    program_modes(make_modes(1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0));
    send_pair(32'h4000_0000, 32'hffff_fffb, 5'd5, 5'd5, 5'd0, 5'd7);
    send_pair(32'h8000_0000, 32'h0000_0000, 5'd31, 5'd0, 5'd6, 5'd0);
    send_pair(32'h7fff_ffff, 32'h0000_0000, 5'd22, 5'd22, 5'd7, 5'd31);
    send_pair(32'h1111_1111, 32'h2222_2222, 5'd10, 5'd3, 5'd4, 5'd4);
    send_pair(32'h3333_3333, 32'h4444_4444, 5'd30, 5'd31, 5'd1, 5'd0);
    send_pair(32'hc000_0001, 32'h0000_0005, 5'd0, 5'd0, 5'd3, 5'd2);

    // mpeg-2 intensity, first scale: odd clamp, even end, illegal with mid/side
    program_modes(make_modes(1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
    send_pair(32'h7fff_ffff, 32'h0000_0007, 5'd22, 5'd22, 5'd31, 5'd0);
    send_pair(32'h8000_0000, 32'h0000_0007, 5'd21, 5'd0, 5'd30, 5'd0);
    send_pair(32'h5555_5555, 32'haaaa_aaaa, 5'd0, 5'd0, 5'd1, 5'd2);
    send_pair(32'h7fff_ffff, 32'h7fff_ffff, 5'd5, 5'd0, 5'd9, 5'd9);

    // mpeg-2 downmix, second scale, unhalved position clamp
    program_modes(make_modes(1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1));
    send_pair(32'h8000_0000, 32'h0000_0003, 5'd22, 5'd0, 5'd31, 5'd0);
    send_pair(32'h7fff_ffff, 32'h0000_0003, 5'd1, 5'd0, 5'd0, 5'd1);
    send_pair(32'h7fff_ffff, 32'h0000_0001, 5'd0, 5'd5, 5'd2, 5'd3);

    // mpeg-1 downmix and mid/side downmix
    program_modes(make_modes(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0));
    send_pair(32'h8000_0001, 32'h1234_0000, 5'd20, 5'd10, 5'd2, 5'd3);
    send_pair(32'hffff_ffff, 32'h8000_0000, 5'd2, 5'd10, 5'd2, 5'd3);

    // random phases over all idling patterns
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       program_modes(make_modes(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
        1:       program_modes(make_modes(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        default: program_modes(random_modes());
      endcase
      case (phase % 4)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 50;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 50;
        end
        default: begin
          idle_pct  = 25;
          stall_pct = 25;
        end
      endcase
      for (int n = 0; n < WORDS_PER_PHASE; n++) send_random_pair();
    end

    // drain and give the pipeline time to show any extra word
    settle();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && words_pending == 0) begin
      $display("mp3_joint_stereo_pair: match");
    end else begin
      $display("mp3_joint_stereo_pair: mismatch");
    end
    $finish;
  end

endmodule
